// ----- src/rx_dma_descriptor_engine_core_assert.svh -----
// Assertion macros shared by the receive DMA descriptor engine.
`ifndef RX_DMA_DESCRIPTOR_ENGINE_CORE_ASSERT_SVH
`define RX_DMA_DESCRIPTOR_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RXDDE_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define RXDDE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define RXDDE_ASSERT_NOW(label, clk, rst_n, a, b)
`define RXDDE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/rxdde_pkg.sv -----
// Types and constants of the receive DMA descriptor engine.
package rxdde_pkg;

	localparam int SLOTS_DEF   = 64;
	localparam int SOURCE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int ROUTE_BITS  = 32;
	localparam int ADDR_BITS   = 64;
	localparam int BYTES_BITS  = 26;

	typedef struct packed {
		logic [SOURCE_BITS-1:0] source;
		logic [ROUTE_BITS-1:0]  route;
		logic [ADDR_BITS-1:0]   address;
		logic [COUNT_BITS-1:0]  total;
		logic [COUNT_BITS-1:0]  received;
	} slot_t;

	typedef enum logic [1:0] {
		CMD_SUBMIT = 2'd0,
		CMD_BURST  = 2'd1,
		CMD_ACK    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNCLAIMED = 3'd1,
		ST_AWAIT     = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_CPL_FULL  = 3'd4,
		ST_REJECTED  = 3'd5,
		ST_ACK_EMPTY = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_CALC,
		S_FIN,
		S_OUT
	} state_t;

endpackage

// ----- src/rxdde_slot_ram.sv -----
// Descriptor slot table: one write port, one registered read port.
module rxdde_slot_ram #(
	parameter int DEPTH = rxdde_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  rxdde_pkg::slot_t         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output rxdde_pkg::slot_t         rd_data
);

	rxdde_pkg::slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/rx_dma_descriptor_engine_core.sv -----
// Receive DMA descriptor engine: descriptor table, burst matching and completion queue.
// Every submit or burst transaction scans all SLOTS descriptors through the one read port of
// the slot table, one slot per cycle; an ack skips the scan. The result may then wait for
// m_tready. The scan finds both the matching source and the lowest free slot. Completions
// are kept in a SLOTS-deep queue read through a registered port.
`include "rx_dma_descriptor_engine_core_assert.svh"
module rx_dma_descriptor_engine_core #(
	parameter int SLOTS = rxdde_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,   // timing_enable
	input  logic         s_tvalid,
	output logic         s_tready,
	// source[15:0] route[47:16] buffer_address[111:48] count[135:112] authorized[136]
	input  logic [143:0] s_tdata,
	input  logic [1:0]   s_tuser,       // cmd[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0] write_enable[3] write_address[67:4] write_bytes[93:68] auth_consumed[94]
	// completion_pushed[95] submit_ready[96] completion_valid[97] completion_source[113:98]
	// completion_route[145:114]
	output logic [151:0] m_tdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int QW = $clog2(2 * SLOTS);
	localparam logic [QW:0]   SLOTS_W = (QW+1)'(SLOTS);
	localparam logic [QW-1:0] RING_LAST = QW'(2 * SLOTS - 1);
	localparam logic [QW-1:0] SLOTS_Q = QW'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	rxdde_pkg::state_t state_q, state_d;

	logic timing_q;
	logic [1:0] cmd_q;
	logic [rxdde_pkg::SOURCE_BITS-1:0] src_q;
	logic [rxdde_pkg::ROUTE_BITS-1:0] route_q;
	logic [rxdde_pkg::ADDR_BITS-1:0] addr_q;
	logic [rxdde_pkg::COUNT_BITS-1:0] count_q;
	logic auth_q;

	logic [SLOTS-1:0] active_q;
	logic [QW-1:0] used_q;
	logic [QW-1:0] head_q, tail_q;

	logic [IW-1:0] idx_q, idx_s1;
	logic vld_s1;
	logic found_q, free_found_q;
	logic [IW-1:0] match_q, free_q;
	rxdde_pkg::slot_t rec_q;
	rxdde_pkg::slot_t rd_data;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	rxdde_pkg::slot_t ram_wdata;

	logic [rxdde_pkg::SOURCE_BITS+rxdde_pkg::ROUTE_BITS-1:0] done_mem [SLOTS];
	logic [rxdde_pkg::SOURCE_BITS+rxdde_pkg::ROUTE_BITS-1:0] done_rd_q;

	rxdde_pkg::status_t res_status_q;
	logic res_wen_q, res_aused_q, res_pushed_q;
	logic [rxdde_pkg::ADDR_BITS-1:0] res_waddr_q;
	logic [rxdde_pkg::BYTES_BITS-1:0] res_wbytes_q;
	logic sready_q, cvalid_q;

	rxdde_pkg::status_t res_status_d;
	logic res_wen_d, res_aused_d, res_pushed_d;
	logic [rxdde_pkg::ADDR_BITS-1:0] res_waddr_d;
	logic [rxdde_pkg::BYTES_BITS-1:0] res_wbytes_d;

	logic [QW-1:0] queued;
	logic [QW:0] load;
	logic [64:0] end_addr;
	logic [rxdde_pkg::COUNT_BITS-1:0] remaining, new_recv;
	logic reject;
	logic push_ok;

	function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
		return (p == RING_LAST) ? '0 : p + QW'(1);
	endfunction

	function automatic logic [IW-1:0] ring_slot(input logic [QW-1:0] p);
		logic [QW-1:0] r;
		r = (p >= SLOTS_Q) ? p - SLOTS_Q : p;
		return r[IW-1:0];
	endfunction

	assign queued = (tail_q >= head_q) ? tail_q - head_q : tail_q + QW'(2 * SLOTS) - head_q;
	assign load = {1'b0, used_q} + {1'b0, queued};
	assign end_addr = {1'b0, addr_q} + {39'd0, count_q, 2'b00};
	assign remaining = rec_q.total - rec_q.received;
	assign new_recv = rec_q.received + count_q;
	assign push_ok = {1'b0, queued} < SLOTS_W;
	assign reject = (count_q == '0) || (addr_q[1:0] != 2'b00) || end_addr[64] || found_q ||
		!(load < SLOTS_W) || !free_found_q || !push_ok;

	assign s_tready = (state_q == rxdde_pkg::S_IDLE);

	rxdde_slot_ram #(.DEPTH(SLOTS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rxdde_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == rxdde_pkg::CMD_SUBMIT || s_tuser == rxdde_pkg::CMD_BURST)
						? rxdde_pkg::S_SCAN : rxdde_pkg::S_CALC;
				end
			end
			rxdde_pkg::S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = rxdde_pkg::S_DRAIN;
				end
			end
			rxdde_pkg::S_DRAIN: state_d = rxdde_pkg::S_CALC;
			rxdde_pkg::S_CALC: state_d = rxdde_pkg::S_FIN;
			rxdde_pkg::S_FIN: state_d = rxdde_pkg::S_OUT;
			rxdde_pkg::S_OUT: begin
				if (!m_tvalid || m_tready) begin
					state_d = rxdde_pkg::S_IDLE;
				end
			end
			default: state_d = rxdde_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rxdde_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = free_q;
		ram_wdata = '{source: src_q, route: route_q, address: addr_q, total: count_q,
			received: '0};
		if (state_q == rxdde_pkg::S_CALC) begin
			if (cmd_q == rxdde_pkg::CMD_SUBMIT && !reject) begin
				ram_we = 1'b1;
			end else if (cmd_q == rxdde_pkg::CMD_BURST && found_q &&
				!(timing_q && !auth_q) && !(count_q > remaining)) begin
				ram_we = 1'b1;
				ram_waddr = match_q;
				ram_wdata = rec_q;
				ram_wdata.received = new_recv;
			end
		end
	end

	always_comb begin
		res_status_d = rxdde_pkg::ST_OK;
		res_wen_d = 1'b0;
		res_waddr_d = '0;
		res_wbytes_d = '0;
		res_aused_d = 1'b0;
		res_pushed_d = 1'b0;
		unique case (cmd_q)
			rxdde_pkg::CMD_SUBMIT: begin
				if (reject) begin
					res_status_d = rxdde_pkg::ST_REJECTED;
				end
			end
			rxdde_pkg::CMD_BURST: begin
				if (!found_q) begin
					res_status_d = rxdde_pkg::ST_UNCLAIMED;
				end else if (timing_q && !auth_q) begin
					res_status_d = rxdde_pkg::ST_AWAIT;
				end else if (count_q > remaining) begin
					res_status_d = rxdde_pkg::ST_OVERFLOW;
				end else begin
					res_wen_d = 1'b1;
					res_waddr_d = rec_q.address + {38'd0, rec_q.received, 2'b00};
					res_wbytes_d = {count_q, 2'b00};
					res_aused_d = timing_q;
					if (new_recv == rec_q.total) begin
						if (push_ok) begin
							res_pushed_d = 1'b1;
						end else begin
							res_status_d = rxdde_pkg::ST_CPL_FULL;
						end
					end
				end
			end
			rxdde_pkg::CMD_ACK: begin
				if (queued == '0) begin
					res_status_d = rxdde_pkg::ST_ACK_EMPTY;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= 1'b0;
			active_q <= '0;
			used_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			idx_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timing_q <= cfg_wr_data;
			end
			vld_s1 <= (state_q == rxdde_pkg::S_SCAN);
			if (state_q == rxdde_pkg::S_SCAN) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
			end
			if (s_tvalid && s_tready) begin
				idx_q <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (vld_s1) begin
				if (active_q[idx_s1] && rd_data.source == src_q && !found_q) begin
					found_q <= 1'b1;
				end
				if (!active_q[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == rxdde_pkg::S_CALC) begin
				unique case (cmd_q)
					rxdde_pkg::CMD_SUBMIT: begin
						if (!reject) begin
							active_q[free_q] <= 1'b1;
							used_q <= used_q + QW'(1);
						end
					end
					rxdde_pkg::CMD_BURST: begin
						if (found_q && !(timing_q && !auth_q) && !(count_q > remaining) &&
							new_recv == rec_q.total && push_ok) begin
							active_q[match_q] <= 1'b0;
							used_q <= used_q - QW'(1);
							tail_q <= ring_next(tail_q);
						end
					end
					rxdde_pkg::CMD_ACK: begin
						if (queued != '0) begin
							head_q <= ring_next(head_q);
						end
					end
					default: ;
				endcase
			end
			if (state_q == rxdde_pkg::S_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser;
			src_q <= s_tdata[15:0];
			route_q <= s_tdata[47:16];
			addr_q <= s_tdata[111:48];
			count_q <= s_tdata[135:112];
			auth_q <= s_tdata[136];
		end
		if (vld_s1) begin
			if (active_q[idx_s1] && rd_data.source == src_q && !found_q) begin
				match_q <= idx_s1;
				rec_q <= rd_data;
			end
			if (!active_q[idx_s1] && !free_found_q) begin
				free_q <= idx_s1;
			end
		end
		if (state_q == rxdde_pkg::S_CALC) begin
			res_status_q <= res_status_d;
			res_wen_q <= res_wen_d;
			res_waddr_q <= res_waddr_d;
			res_wbytes_q <= res_wbytes_d;
			res_aused_q <= res_aused_d;
			res_pushed_q <= res_pushed_d;
			if (res_pushed_d) begin
				done_mem[ring_slot(tail_q)] <= {rec_q.route, rec_q.source};
			end
		end
		if (state_q == rxdde_pkg::S_FIN) begin
			done_rd_q <= done_mem[ring_slot(head_q)];
			sready_q <= (load < SLOTS_W) && push_ok;
			cvalid_q <= (queued != '0);
		end
		if (state_q == rxdde_pkg::S_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {6'd0,
				cvalid_q ? done_rd_q : 48'd0,
				cvalid_q, sready_q, res_pushed_q, res_aused_q,
				res_wbytes_q, res_waddr_q, res_wen_q, res_status_q};
		end
	end

	`RXDDE_ASSERT_NOW(a_used_count, clk, arst_n, 1'b1, {1'b0, used_q} == (QW+1)'($countones(active_q)))
	`RXDDE_ASSERT_NOW(a_capacity, clk, arst_n, 1'b1, load <= SLOTS_W)
	`RXDDE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

// ----- verif/tb_rx_dma_descriptor_engine_core.sv -----
// Testbench for the receive DMA descriptor engine: directed table, random traffic, predictor.
`timescale 1ns / 1ps
module tb_rx_dma_descriptor_engine_core;

	localparam int NSLOT = 64;
	localparam int RING  = 2 * NSLOT;

	typedef struct {
		rxdde_pkg::cmd_t cmd;
		logic [15:0]     source;
		logic [31:0]     route;
		logic [63:0]     addr;
		logic [23:0]     count;
		logic            auth;
	} desc_item_t;

	typedef struct {
		rxdde_pkg::status_t status;
		logic               wen;
		logic [63:0]        waddr;
		logic [25:0]        wbytes;
		logic               aused;
		logic               pushed;
		logic               sready;
		logic               cvalid;
		logic [15:0]        csrc;
		logic [31:0]        croute;
	} dma_result_t;

	typedef struct {
		int         timing;
		desc_item_t it;
		int         status;
	} table_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wr_en;
	logic         cfg_wr_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;

	rx_dma_descriptor_engine_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	logic        timing_on;
	logic        act[NSLOT];
	logic [15:0] sl_src[NSLOT];
	logic [31:0] sl_route[NSLOT];
	logic [63:0] sl_addr[NSLOT];
	logic [23:0] sl_total[NSLOT];
	logic [23:0] sl_rcvd[NSLOT];
	logic [15:0] cq_src[NSLOT];
	logic [31:0] cq_route[NSLOT];
	int          cq_head, cq_tail;

	dma_result_t expected_q[$];
	int          typed_status_q[$];
	int          mismatches;
	int          send_idle_pct, recv_idle_pct, hold_req;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic int queued();
		return (cq_tail + RING - cq_head) % RING;
	endfunction

	function automatic int find_src(logic [15:0] s);
		for (int i = 0; i < NSLOT; i++)
			if (act[i] && sl_src[i] == s) return i;
		return -1;
	endfunction

	function automatic int find_free();
		for (int i = 0; i < NSLOT; i++)
			if (!act[i]) return i;
		return -1;
	endfunction

	function automatic logic can_submit();
		int used;
		used = 0;
		for (int i = 0; i < NSLOT; i++)
			if (act[i]) used++;
		return used + queued() < NSLOT && find_free() >= 0 && queued() < NSLOT;
	endfunction

	function automatic dma_result_t predict_descriptor(desc_item_t it);
		dma_result_t r;
		logic [63:0] bytes;
		int s, w;
		r = '{rxdde_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		bytes = {40'd0, it.count} << 2;
		case (it.cmd)
			rxdde_pkg::CMD_SUBMIT: begin
				if (it.count == 0 || it.addr[1:0] != 0 || it.addr > ~64'd0 - bytes ||
				    find_src(it.source) >= 0 || !can_submit()) begin
					r.status = rxdde_pkg::ST_REJECTED;
				end else begin
					s = find_free();
					act[s] = 1; sl_src[s] = it.source; sl_route[s] = it.route;
					sl_addr[s] = it.addr; sl_total[s] = it.count; sl_rcvd[s] = 0;
				end
			end
			rxdde_pkg::CMD_BURST: begin
				s = find_src(it.source);
				if (s < 0) begin
					r.status = rxdde_pkg::ST_UNCLAIMED;
				end else if (timing_on && !it.auth) begin
					r.status = rxdde_pkg::ST_AWAIT;
				end else if (it.count > sl_total[s] - sl_rcvd[s]) begin
					r.status = rxdde_pkg::ST_OVERFLOW;
				end else begin
					r.wen = 1;
					r.waddr = sl_addr[s] + ({40'd0, sl_rcvd[s]} << 2);
					r.wbytes = bytes[25:0];
					r.aused = timing_on;
					sl_rcvd[s] += it.count;
					if (sl_rcvd[s] == sl_total[s]) begin
						if (queued() < NSLOT) begin
							w = cq_tail % NSLOT;
							cq_src[w] = sl_src[s]; cq_route[w] = sl_route[s];
							cq_tail = (cq_tail + 1) % RING;
							act[s] = 0;
							r.pushed = 1;
						end else begin
							r.status = rxdde_pkg::ST_CPL_FULL;
						end
					end
				end
			end
			rxdde_pkg::CMD_ACK: begin
				if (queued() == 0) r.status = rxdde_pkg::ST_ACK_EMPTY;
				else cq_head = (cq_head + 1) % RING;
			end
			default: ;
		endcase
		r.sready = can_submit();
		if (queued() != 0) begin
			r.cvalid = 1;
			r.csrc = cq_src[cq_head % NSLOT];
			r.croute = cq_route[cq_head % NSLOT];
		end
		return r;
	endfunction

	function automatic void field_check(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, e, a);
		end
	endfunction

	always @(posedge clk) begin
		dma_result_t e;
		int ts;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: result with nothing expected");
			end else begin
				e = expected_q.pop_front();
				ts = typed_status_q.pop_front();
				if (ts >= 0) field_check("typed status", ts, m_tdata[2:0]);
				field_check("status", e.status, m_tdata[2:0]);
				field_check("write_enable", e.wen, m_tdata[3]);
				field_check("write_address", e.waddr, m_tdata[67:4]);
				field_check("write_bytes", e.wbytes, m_tdata[93:68]);
				field_check("auth_consumed", e.aused, m_tdata[94]);
				field_check("completion_pushed", e.pushed, m_tdata[95]);
				field_check("submit_ready", e.sready, m_tdata[96]);
				field_check("completion_valid", e.cvalid, m_tdata[97]);
				field_check("completion_source", e.csrc, m_tdata[113:98]);
				field_check("completion_route", e.croute, m_tdata[145:114]);
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			m_tready <= 1'b0;
			hold_req <= hold_req - 1;
		end else begin
			m_tready <= ($urandom % 100) >= recv_idle_pct;
		end
	end

	task automatic send_descriptor(desc_item_t it, int typed_status);
		while (($urandom % 100) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.cmd;
		s_tdata  <= {7'd0, it.auth, it.count, it.addr, it.route, it.source};
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(predict_descriptor(it));
		typed_status_q.push_back(typed_status);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		wait (expected_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_timing(logic v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		timing_on = v;
	endtask

	function automatic table_row_t row(int timing, rxdde_pkg::cmd_t c, logic [15:0] s,
	                                   logic [31:0] rt, logic [63:0] a, logic [23:0] n,
	                                   logic au, int st);
		table_row_t t;
		t.timing = timing;
		t.it = '{c, s, rt, a, n, au};
		t.status = st;
		return t;
	endfunction

	task automatic random_descriptor(int ack_pct, int sub_pct, int pool, output desc_item_t it);
		int r, live[$], s;
		logic [23:0] rem;
		it.source = $urandom; it.route = $urandom; it.addr = {$urandom, $urandom};
		it.count = $urandom; it.auth = $urandom;
		r = $urandom % 100;
		if (r < 3) begin
			it.cmd = rxdde_pkg::CMD_NONE;
		end else if (r < 3 + ack_pct) begin
			it.cmd = rxdde_pkg::CMD_ACK;
		end else if (r < 3 + ack_pct + sub_pct) begin
			it.cmd = rxdde_pkg::CMD_SUBMIT;
			if ($urandom % 20 != 0) it.source = $urandom % pool;
			if ($urandom % 10 != 0) it.addr[1:0] = 2'b00;
			if ($urandom % 50 == 0) it.addr = ~64'd3 - ($urandom_range(0, 16) << 2);
			r = $urandom % 100;
			if (r < 85) it.count = $urandom_range(1, 8);
			else if (r < 90) it.count = 0;
		end else begin
			it.cmd = rxdde_pkg::CMD_BURST;
			for (int i = 0; i < NSLOT; i++)
				if (act[i]) live.push_back(i);
			if (live.size() > 0 && $urandom % 100 < 85) begin
				s = live[$urandom % live.size()];
				it.source = sl_src[s];
				rem = sl_total[s] - sl_rcvd[s];
				r = $urandom % 100;
				if (r < 10) it.count = rem + $urandom_range(1, 4);
				else if (r < 50) it.count = rem;
				else it.count = $urandom_range(0, rem > 8 ? 8 : rem);
				if (timing_on && $urandom % 100 < 85) it.auth = 1;
			end else if ($urandom % 10 != 0) begin
				it.source = $urandom % pool;
			end
		end
	endtask

	task automatic random_phase(int n, int ack_pct, int sub_pct, int pool);
		desc_item_t it;
		for (int i = 0; i < n; i++) begin
			random_descriptor(ack_pct, sub_pct, pool, it);
			send_descriptor(it, -1);
		end
	endtask

	initial begin
		table_row_t dir[$];
		arst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = rxdde_pkg::CMD_NONE; m_tready = 1'b0;
		mismatches = 0; hold_req = 0; send_idle_pct = 23; recv_idle_pct = 79;
		timing_on = 0; cq_head = 0; cq_tail = 0;
		for (int i = 0; i < NSLOT; i++) act[i] = 0;

		dir.push_back(row(-1, rxdde_pkg::CMD_ACK, 0, 0, 0, 0, 0, rxdde_pkg::ST_ACK_EMPTY));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 5, 0, 0, 1, 1, rxdde_pkg::ST_UNCLAIMED));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 3, 7, 64'h100, 0, 0,
			rxdde_pkg::ST_REJECTED));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 3, 7, 64'h102, 4, 0,
			rxdde_pkg::ST_REJECTED));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 3, 7, ~64'd3, 2, 0,
			rxdde_pkg::ST_REJECTED));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 16'hFFFF, '1, 64'h0, 24'hFFFFFF, 0,
			rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 16'hFFFF, 1, 64'h40, 1, 0,
			rxdde_pkg::ST_REJECTED));
		dir.push_back(row(-1, rxdde_pkg::CMD_SUBMIT, 1, 32'h1234, ~64'd11, 2, 0,
			rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 1, 0, 0, 3, 0, rxdde_pkg::ST_OVERFLOW));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 1, 0, 0, 0, 0, rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 1, 0, 0, 2, 0, rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 1, 0, 0, 0, 0, rxdde_pkg::ST_UNCLAIMED));
		dir.push_back(row(-1, rxdde_pkg::CMD_ACK, 0, 0, 0, 0, 0, rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_ACK, 0, 0, 0, 0, 0, rxdde_pkg::ST_ACK_EMPTY));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 16'hFFFF, 0, 0, 24'hFFFFFF, 1,
			rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_NONE, '1, '1, '1, '1, 1, rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_ACK, 0, 0, 0, 0, 0, rxdde_pkg::ST_OK));
		dir.push_back(row(1, rxdde_pkg::CMD_SUBMIT, 2, 32'h55, 64'h100, 1, 0,
			rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 2, 0, 0, 1, 0, rxdde_pkg::ST_AWAIT));
		dir.push_back(row(-1, rxdde_pkg::CMD_BURST, 2, 0, 0, 1, 1, rxdde_pkg::ST_OK));
		dir.push_back(row(-1, rxdde_pkg::CMD_ACK, 0, 0, 0, 0, 0, rxdde_pkg::ST_OK));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			if (dir[i].timing >= 0) write_timing(dir[i].timing);
			send_descriptor(dir[i].it, dir[i].status);
		end

		write_timing(0);
		random_phase(350, 15, 35, 12);

		send_idle_pct = 79; recv_idle_pct = 23;
		write_timing(1);
		random_phase(150, 15, 35, 12);
		send_idle_pct = 0;
		hold_req = 400;
		random_phase(40, 15, 35, 12);
		send_idle_pct = 79;
		drain_results();
		random_phase(160, 15, 35, 12);

		send_idle_pct = 0; recv_idle_pct = 0;
		write_timing(0);
		random_phase(300, 2, 45, 80);
		write_timing(1);
		random_phase(300, 25, 30, 12);

		drain_results();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- rx_dma_descriptor_engine_core.f -----
+incdir+src
src/rxdde_pkg.sv
src/rxdde_slot_ram.sv
src/rx_dma_descriptor_engine_core.sv
verif/tb_rx_dma_descriptor_engine_core.sv
